// ===== hw/rtl/hangul_jamo_syllable_composer_defines.svh =====
// assertion helpers for the syllable composer
`ifndef HANGUL_JAMO_SYLLABLE_COMPOSER_DEFINES_SVH
`define HANGUL_JAMO_SYLLABLE_COMPOSER_DEFINES_SVH
`ifndef SYNTHESIS
`define HJSC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define HJSC_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define HJSC_ASSERT(label, clk, rst_n, prop, msg)
`define HJSC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/hjsc_pkg.sv =====
`default_nettype none
package hjsc_pkg;
    localparam logic [15:0] SYL_BASE    = 16'hAC00;
    localparam logic [15:0] CONS_FIRST  = 16'h3131;
    localparam logic [15:0] CONS_LAST   = 16'h314E;
    localparam logic [15:0] VOW_FIRST   = 16'h314F;
    localparam logic [15:0] VOW_LAST    = 16'h3163;
    localparam logic [15:0] CONS_ORIGIN = 16'h3130;
    localparam logic [15:0] VOW_ORIGIN  = 16'h314E;

    // one result word
    typedef struct packed {
        logic [15:0] code;
        logic        comp;
        logic        last;
    } t_res;

    // work handed from front to back: optional commit word, then final word
    typedef struct packed {
        logic        has_commit;
        logic [15:0] commit_code;
        logic [15:0] final_code;
        logic        final_comp;
    } t_job;

    // initial index by consonant index
    function automatic logic [4:0] init_idx(input logic [5:0] c);
        case (c)
            6'd1: init_idx = 5'd0;   6'd2: init_idx = 5'd1;   6'd4: init_idx = 5'd2;
            6'd7: init_idx = 5'd3;   6'd8: init_idx = 5'd4;   6'd9: init_idx = 5'd5;
            6'd17: init_idx = 5'd6;  6'd18: init_idx = 5'd7;  6'd19: init_idx = 5'd8;
            6'd21: init_idx = 5'd9;  6'd22: init_idx = 5'd10; 6'd23: init_idx = 5'd11;
            6'd24: init_idx = 5'd12; 6'd25: init_idx = 5'd13; 6'd26: init_idx = 5'd14;
            6'd27: init_idx = 5'd15; 6'd28: init_idx = 5'd16; 6'd29: init_idx = 5'd17;
            6'd30: init_idx = 5'd18;
            default: init_idx = 5'd0;
        endcase
    endfunction

    // final index before the plus one
    function automatic logic [4:0] fin_idx(input logic [5:0] c);
        case (c)
            6'd2: fin_idx = 5'd1;   6'd3: fin_idx = 5'd2;   6'd4: fin_idx = 5'd3;
            6'd5: fin_idx = 5'd4;   6'd6: fin_idx = 5'd5;   6'd7: fin_idx = 5'd6;
            6'd9: fin_idx = 5'd7;   6'd10: fin_idx = 5'd8;  6'd11: fin_idx = 5'd9;
            6'd12: fin_idx = 5'd10; 6'd13: fin_idx = 5'd11; 6'd14: fin_idx = 5'd12;
            6'd15: fin_idx = 5'd13; 6'd16: fin_idx = 5'd14; 6'd17: fin_idx = 5'd15;
            6'd18: fin_idx = 5'd16; 6'd20: fin_idx = 5'd17; 6'd21: fin_idx = 5'd18;
            6'd22: fin_idx = 5'd19; 6'd23: fin_idx = 5'd20; 6'd24: fin_idx = 5'd21;
            6'd26: fin_idx = 5'd22; 6'd27: fin_idx = 5'd23; 6'd28: fin_idx = 5'd24;
            6'd29: fin_idx = 5'd25; 6'd30: fin_idx = 5'd26;
            default: fin_idx = 5'd0;
        endcase
    endfunction

    function automatic logic [5:0] pair_cons(input logic [5:0] a, input logic [5:0] b);
        if (a == 6'd0) pair_cons = b;
        else if (b == 6'd0) pair_cons = a;
        else begin
            case (a)
                6'd1: pair_cons = (b == 6'd21) ? 6'd3 : 6'd0;
                6'd4: pair_cons = (b == 6'd24) ? 6'd5 : ((b == 6'd30) ? 6'd6 : 6'd0);
                6'd9: begin
                    case (b)
                        6'd1: pair_cons = 6'd10;
                        6'd17: pair_cons = 6'd11;
                        6'd18: pair_cons = 6'd12;
                        6'd21: pair_cons = 6'd13;
                        6'd28: pair_cons = 6'd14;
                        6'd29: pair_cons = 6'd15;
                        6'd30: pair_cons = 6'd16;
                        default: pair_cons = 6'd0;
                    endcase
                end
                6'd18: pair_cons = (b == 6'd21) ? 6'd20 : 6'd0;
                default: pair_cons = 6'd0;
            endcase
        end
    endfunction

    function automatic logic [4:0] pair_vow(input logic [4:0] a, input logic [4:0] b);
        if (a == 5'd0) pair_vow = b;
        else if (b == 5'd0) pair_vow = a;
        else begin
            case (a)
                5'd9: pair_vow = (b == 5'd1) ? 5'd10 : ((b == 5'd2) ? 5'd11 :
                                 ((b == 5'd21) ? 5'd12 : 5'd0));
                5'd14: pair_vow = (b == 5'd5) ? 5'd15 : ((b == 5'd6) ? 5'd16 :
                                  ((b == 5'd21) ? 5'd17 : 5'd0));
                5'd19: pair_vow = (b == 5'd21) ? 5'd20 : 5'd0;
                default: pair_vow = 5'd0;
            endcase
        end
    endfunction

    function automatic logic compound_only(input logic [5:0] c);
        compound_only = (c == 6'd3) || (c == 6'd5) || (c == 6'd6) ||
                        (c >= 6'd10 && c <= 6'd16) || (c == 6'd20);
    endfunction

    function automatic logic non_final(input logic [5:0] c);
        non_final = (c == 6'd8) || (c == 6'd19) || (c == 6'd25);
    endfunction

    // code of a syllable or of a lone jamo, zero when empty: one small multiply-add
    function automatic logic [15:0] compose_code(input logic [5:0] ini,
                                                 input logic [4:0] v1,
                                                 input logic [4:0] v2,
                                                 input logic [5:0] f1,
                                                 input logic [5:0] f2);
        logic [4:0] med;
        logic [5:0] fin;
        med = pair_vow(v1, v2);
        fin = pair_cons(f1, f2);
        if (ini == 6'd0) compose_code = (med == 5'd0) ? 16'd0 : VOW_ORIGIN + 16'(med);
        else if (med == 5'd0) compose_code = CONS_ORIGIN + 16'(ini);
        else compose_code = SYL_BASE + 16'(init_idx(ini)) * 16'd588 +
                            16'(med - 5'd1) * 16'd28 +
                            ((fin != 6'd0) ? 16'(fin_idx(fin)) + 16'd1 : 16'd0);
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/hjsc_stream_if.sv =====
`default_nettype none
interface hjsc_stream_if #(parameter int W = 16);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/hjsc_front.sv =====
`default_nettype none
module hjsc_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [15:0]  i_char_code,
    output logic              o_job_valid,
    input  wire logic         i_job_ready,
    output hjsc_pkg::t_job    o_job
);
    import hjsc_pkg::*;

    // syllable state
    logic [5:0] r_ini, n_ini, r_f1, n_f1, r_f2, n_f2;
    logic [4:0] r_v1, n_v1, r_v2, n_v2;
    logic        is_cons, is_vow, take, commit;
    logic [5:0]  c, moved;
    logic [4:0]  v;
    // finals left in the committed syllable once a moved final is taken out
    logic [5:0]  k_f1, k_f2;
    logic [15:0] commit_code, syl_code;

    assign o_ready = i_job_ready;
    assign take    = i_valid && i_job_ready;
    assign is_cons = i_char_code >= CONS_FIRST && i_char_code <= CONS_LAST;
    assign is_vow  = i_char_code >= VOW_FIRST && i_char_code <= VOW_LAST;
    assign c       = 6'(i_char_code - CONS_ORIGIN);
    assign v       = 5'(i_char_code - VOW_ORIGIN);

    // next syllable state
    always_comb begin
        n_ini = r_ini; n_v1 = r_v1; n_v2 = r_v2; n_f1 = r_f1; n_f2 = r_f2;
        k_f1 = r_f1; k_f2 = r_f2;
        commit = 1'b0;
        moved = 6'd0;
        if (is_cons) begin
            if (r_ini == 6'd0 || r_v1 == 5'd0 || r_f2 != 6'd0 ||
                (r_f1 != 6'd0 && pair_cons(r_f1, c) == 6'd0) || non_final(c)) begin
                commit = 1'b1;
                n_ini = c; n_v1 = 5'd0; n_v2 = 5'd0; n_f1 = 6'd0; n_f2 = 6'd0;
            end else if (r_f1 == 6'd0) n_f1 = c;
            else n_f2 = c;
        end else if (is_vow) begin
            if (r_f1 != 6'd0) begin
                if (r_f2 != 6'd0) begin
                    moved = r_f2;
                    k_f2 = 6'd0;
                end else if (!compound_only(r_f1)) begin
                    moved = r_f1;
                    k_f1 = 6'd0;
                end
                commit = 1'b1;
                n_ini = moved; n_v1 = v; n_v2 = 5'd0; n_f1 = 6'd0; n_f2 = 6'd0;
            end else if ((r_v1 == 5'd0 && compound_only(r_ini)) || r_v2 != 5'd0 ||
                         (r_v1 != 5'd0 && pair_vow(r_v1, v) == 5'd0)) begin
                commit = 1'b1;
                n_ini = 6'd0; n_v1 = v; n_v2 = 5'd0; n_f1 = 6'd0; n_f2 = 6'd0;
            end else if (r_v1 == 5'd0) n_v1 = v;
            else n_v2 = v;
        end else begin
            commit = 1'b1;
            n_ini = 6'd0; n_v1 = 5'd0; n_v2 = 5'd0; n_f1 = 6'd0; n_f2 = 6'd0;
        end
    end

    // committed syllable and the syllable still being composed
    assign commit_code = compose_code(r_ini, r_v1, r_v2, k_f1, k_f2);
    assign syl_code    = compose_code(n_ini, n_v1, n_v2, n_f1, n_f2);

    // job to the queue
    always_comb begin
        o_job_valid      = i_valid;
        o_job.has_commit = commit && commit_code != 16'd0;
        o_job.commit_code = commit_code;
        o_job.final_code = (is_cons || is_vow) ? syl_code : i_char_code;
        o_job.final_comp = is_cons || is_vow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ini <= 6'd0; r_v1 <= 5'd0; r_v2 <= 5'd0; r_f1 <= 6'd0; r_f2 <= 6'd0;
        end else if (take) begin
            r_ini <= n_ini; r_v1 <= n_v1; r_v2 <= n_v2; r_f1 <= n_f1; r_f2 <= n_f2;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/hjsc_queue.sv =====
`default_nettype none
`include "hangul_jamo_syllable_composer_defines.svh"
module hjsc_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  hjsc_pkg::t_job i_job,
    output logic           o_valid,
    input  wire logic      i_ready,
    output hjsc_pkg::t_job o_job
);
    import hjsc_pkg::*;

    // two-entry fifo
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    `HJSC_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3, "queue count out of range")
    `HJSC_ASSERT(a_no_pop_empty, i_clk, i_rst_n, (r_cnt == 2'd0) |-> !pop, "pop while empty")
    `HJSC_ASSERT(a_cnt_track, i_clk, i_rst_n,
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 2'd1), "count did not rise on push")
endmodule
`default_nettype wire

// ===== hw/rtl/hjsc_back.sv =====
`default_nettype none
module hjsc_back (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  hjsc_pkg::t_job i_job,
    output logic           o_valid,
    input  wire logic      i_ready,
    output hjsc_pkg::t_res o_res
);
    import hjsc_pkg::*;

    // phase: set once the commit word of the head job has gone out
    logic r_phase;
    logic emit_commit, out_take;

    assign emit_commit = i_job.has_commit && !r_phase;
    assign o_valid     = i_valid;
    assign out_take    = i_valid && i_ready;
    assign o_ready     = i_ready && !emit_commit;

    always_comb begin
        o_res.code = emit_commit ? i_job.commit_code : i_job.final_code;
        o_res.comp = emit_commit ? 1'b0 : i_job.final_comp;
        o_res.last = !emit_commit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_phase <= 1'b0;
        else if (out_take) r_phase <= emit_commit;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/hangul_jamo_syllable_composer.sv =====
// Hangul two-set syllable composer.
// Input channel i_in carries one 16-bit character word per handshake
// (valid/ready). Output channel o_out carries result words {out_code,
// composing, last}; each input gives one or two words, the last marked.
// A front stage updates the syllable state and builds a job, a two-entry
// queue decouples it from a back stage that emits the commit word and then
// the final word, one word per cycle while the receiver does not stall.
// The first word of an input is registered in the queue and then in the
// output register before the receiver can take it.
// Throughput: one input per cycle when it gives a single word and the
// receiver does not stall; an input that also commits a syllable holds the
// single output port for both its words. Reset (synchronous, active low)
// empties the syllable and the queue. When the receiver stalls, the output
// word holds, the queue fills and then input ready drops; no word is lost.
`default_nettype none
`include "hangul_jamo_syllable_composer_defines.svh"
module hangul_jamo_syllable_composer (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    hjsc_stream_if.sink   i_in,
    hjsc_stream_if.source o_out
);
    import hjsc_pkg::*;

    t_job   f_job, q_job;
    t_res   b_res;
    logic   f_valid, f_ready, q_valid, q_ready;
    logic   b_valid, b_ready;
    t_res   r_out;
    logic   r_out_valid;

    hjsc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in.valid), .o_ready(i_in.ready), .i_char_code(i_in.data[15:0]),
        .o_job_valid(f_valid), .i_job_ready(f_ready), .o_job(f_job)
    );

    hjsc_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready), .i_job(f_job),
        .o_valid(q_valid), .i_ready(q_ready), .o_job(q_job)
    );

    hjsc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_job(q_job),
        .o_valid(b_valid), .i_ready(b_ready), .o_res(b_res)
    );

    // output register
    assign b_ready     = !r_out_valid || o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (b_ready) r_out_valid <= b_valid;
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && b_valid) r_out <= b_res;
    end

    `HJSC_ASSERT(a_hold, i_clk, i_rst_n,
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.data)),
        "stalled output word changed")
    `HJSC_ASSERT(a_commit_first, i_clk, i_rst_n,
        (o_out.valid && !o_out.data[0]) |-> !o_out.data[1], "commit word flagged as composing")
    `HJSC_ASSERT_NR(a_rst, i_clk, !i_rst_n |=> !o_out.valid, "output valid after reset")
endmodule
`default_nettype wire
